@@ rtl/flow_gyro_compensator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// flow gyro compensator assertion macros
// shared property wrappers, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef FLOW_GYRO_COMPENSATOR_UNIT_MACROS_SVH
`define FLOW_GYRO_COMPENSATOR_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define FGC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fgc assertion failed");

// consequent checked in the cycle after the antecedent
`define FGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fgc assertion failed");

`endif

@@ rtl/fgc_pkg.sv @@
// ----------------------------------------------------------------------------
// fgc_pkg
// widths, reset values, codes and control types of the flow gyro compensator
// ----------------------------------------------------------------------------
package fgc_pkg;

  // sample and filter format
  localparam int SAMPLE_WIDTH     = 16;
  localparam int FILTER_FRAC_BITS = 16;

  // field and state widths
  localparam int ALPHA_W    = 16;
  localparam int ALPHA_FRAC = 16;
  localparam int GAIN_W     = 24;
  localparam int GAIN_FRAC  = 24;
  localparam int WIN_FRAC   = 16;
  localparam int OUT_FRAC   = 8;
  localparam int FILT_W     = 32;
  localparam int WIN_W      = 40;
  localparam int FLOW_W     = 16;
  localparam int OUT_W      = 24;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [ALPHA_W-1:0]       ALPHA_X_RST   = ALPHA_W'(3874);
  localparam logic [ALPHA_W-1:0]       ALPHA_Y_RST   = ALPHA_W'(2761);
  localparam logic signed [GAIN_W-1:0] GAIN_DT_X_RST = GAIN_W'(134380);
  localparam logic signed [GAIN_W-1:0] GAIN_DT_Y_RST = GAIN_W'(153015);

  // filter difference: rate scaled to filter format minus filter state
  localparam int RATE_SH_W = SAMPLE_WIDTH + FILTER_FRAC_BITS;
  localparam int DIFF_W    = ((RATE_SH_W > FILT_W) ? RATE_SH_W : FILT_W) + 1;

  // serial multiplier: multiplicand a, multiplier b shifted out lsb first
  localparam int MUL_A_W  = DIFF_W;
  localparam int MUL_B_W  = ((ALPHA_W > GAIN_W) ? ALPHA_W : GAIN_W) + 1;
  localparam int MUL_HI_W = MUL_A_W + 1;
  localparam int MUL_P_W  = MUL_HI_W + MUL_B_W;
  localparam int CNT_W    = $clog2(MUL_B_W);

  // filter step
  localparam int PROD1_W = DIFF_W + ALPHA_W + 1;
  localparam int STEP_W  = PROD1_W - ALPHA_FRAC;
  localparam int FSUM_W  = ((STEP_W > FILT_W) ? STEP_W : FILT_W) + 1;

  // window step
  localparam int GAIN_K  = GAIN_FRAC + FILTER_FRAC_BITS - WIN_FRAC;
  localparam int PROD2_W = GAIN_W + FILT_W;
  localparam int ADD_W   = PROD2_W - GAIN_K;
  localparam int WSUM_W  = ((ADD_W > WIN_W) ? ADD_W : WIN_W) + 1;

  // flow frame
  localparam int RND_SH  = WIN_FRAC - OUT_FRAC;
  localparam int SUB_W   = WIN_W + 1 - RND_SH;
  localparam int FSH_W   = FLOW_W + OUT_FRAC;
  localparam int CDIFF_W = ((FSH_W > SUB_W) ? FSH_W : SUB_W) + 1;

  typedef enum logic {
    CMD_GYRO = 1'b0,
    CMD_FLOW = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_X,
    CFG_ALPHA_Y,
    CFG_GAIN_DT_X,
    CFG_GAIN_DT_Y
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_FILT,
    ST_UPD_FILT,
    ST_MUL_WIN,
    ST_UPD_WIN,
    ST_FLOW_OUT
  } state_e;

  typedef struct packed {
    logic load_filt;
    logic load_flow;
    logic mul_step;
    logic mul_last;
    logic upd_filt;
    logic upd_win;
    logic flow_out;
  } axis_ctrl_t;

endpackage

@@ rtl/fgc_in_if.sv @@
// ----------------------------------------------------------------------------
// fgc_in_if
// input word channel: gyro sample or flow frame
// ----------------------------------------------------------------------------
interface fgc_in_if import fgc_pkg::*; ();
  logic                           valid;
  logic                           ready;
  cmd_e                           command;
  logic signed [SAMPLE_WIDTH-1:0] rate_x;
  logic signed [SAMPLE_WIDTH-1:0] rate_y;
  logic signed [FLOW_W-1:0]       flow_dx;
  logic signed [FLOW_W-1:0]       flow_dy;

  modport source (output valid, command, rate_x, rate_y, flow_dx, flow_dy, input ready);
  modport sink   (input valid, command, rate_x, rate_y, flow_dx, flow_dy, output ready);
endinterface

@@ rtl/fgc_out_if.sv @@
// ----------------------------------------------------------------------------
// fgc_out_if
// result word channel: compensated flow deltas
// ----------------------------------------------------------------------------
interface fgc_out_if import fgc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] comp_dx;
  logic signed [OUT_W-1:0] comp_dy;

  modport source (output valid, comp_dx, comp_dy, input ready);
  modport sink   (input valid, comp_dx, comp_dy, output ready);
endinterface

@@ rtl/fgc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// fgc_cfg_if
// register write channel: index and data
// ----------------------------------------------------------------------------
interface fgc_cfg_if import fgc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_idx_e              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/flow_gyro_compensator_unit.sv @@
// ----------------------------------------------------------------------------
// flow_gyro_compensator_unit
// two-axis gyro rotation compensation of optical flow deltas
// ----------------------------------------------------------------------------
// in_i carries gyro sample words (command gyro) and flow frame words
// (command flow). cfg_i writes alpha_x, alpha_y, gain_dt_x, gain_dt_y by
// index and is always ready; write it only while the block is idle.
// out_o returns one word of compensated deltas per flow frame.
// a gyro sample runs both axes side by side through a bit-serial
// multiplier, one multiplier bit per cycle: a load step, the filter
// product, a filter update, the window product and a window update,
// and only then is the next word taken.
// a flow frame is held in the frame registers, then its result goes to
// the output register, and the block is back in idle for the next word.
// reset clears filters and window sums and restores the default register
// values. a result waiting on out_o sits in the output register; gyro
// samples keep flowing, and a new flow frame holds in its final step until
// the output register is free.
// ----------------------------------------------------------------------------
module flow_gyro_compensator_unit import fgc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  fgc_in_if.sink        in_i,
  fgc_out_if.source     out_o,
  fgc_cfg_if.sink       cfg_i
);

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  axis_ctrl_t               ctrl;
  logic                     in_ready;
  logic                     out_load;
  logic                     out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0]  comp_x_q, comp_y_q;
  logic signed [OUT_W-1:0]  comp_x, comp_y;

  logic [ALPHA_W-1:0]       alpha_x_q, alpha_y_q;
  logic signed [GAIN_W-1:0] gain_x_q, gain_y_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_x_q <= ALPHA_X_RST;
      alpha_y_q <= ALPHA_Y_RST;
      gain_x_q  <= GAIN_DT_X_RST;
      gain_y_q  <= GAIN_DT_Y_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ALPHA_X:   alpha_x_q <= cfg_i.data[ALPHA_W-1:0];
        CFG_ALPHA_Y:   alpha_y_q <= cfg_i.data[ALPHA_W-1:0];
        CFG_GAIN_DT_X: gain_x_q  <= cfg_i.data[GAIN_W-1:0];
        CFG_GAIN_DT_Y: gain_y_q  <= cfg_i.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ctrl     = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.command == CMD_FLOW) begin
            ctrl.load_flow = 1'b1;
            state_d        = ST_FLOW_OUT;
          end else begin
            ctrl.load_filt = 1'b1;
            cnt_d          = '0;
            state_d        = ST_MUL_FILT;
          end
        end
      end
      ST_MUL_FILT, ST_MUL_WIN: begin
        ctrl.mul_step = 1'b1;
        ctrl.mul_last = (cnt_q == CNT_W'(MUL_B_W - 1));
        if (ctrl.mul_last) begin
          state_d = (state_q == ST_MUL_FILT) ? ST_UPD_FILT : ST_UPD_WIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_UPD_FILT: begin
        ctrl.upd_filt = 1'b1;
        cnt_d         = '0;
        state_d       = ST_MUL_WIN;
      end
      ST_UPD_WIN: begin
        ctrl.upd_win = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_FLOW_OUT: begin
        // wait for a free output register
        if (!out_valid_q || out_o.ready) begin
          ctrl.flow_out = 1'b1;
          out_load      = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready = in_ready;

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      comp_x_q <= comp_x;
      comp_y_q <= comp_y;
    end
  end

  fgc_axis u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .alpha_i (alpha_x_q),
    .gain_i  (gain_x_q),
    .rate_i  (in_i.rate_x),
    .flow_i  (in_i.flow_dx),
    .comp_o  (comp_x)
  );

  fgc_axis u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .alpha_i (alpha_y_q),
    .gain_i  (gain_y_q),
    .rate_i  (in_i.rate_y),
    .flow_i  (in_i.flow_dy),
    .comp_o  (comp_y)
  );

  assign out_o.valid   = out_valid_q;
  assign out_o.comp_dx = comp_x_q;
  assign out_o.comp_dy = comp_y_q;

endmodule

@@ rtl/fgc_axis.sv @@
// ----------------------------------------------------------------------------
// fgc_axis
// one compensation axis: low-pass filter, window sum, flow correction,
// with a bit-serial shift-add multiplier
// ----------------------------------------------------------------------------
module fgc_axis import fgc_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  axis_ctrl_t                     ctrl_i,
  input  logic [ALPHA_W-1:0]             alpha_i,
  input  logic signed [GAIN_W-1:0]       gain_i,
  input  logic signed [SAMPLE_WIDTH-1:0] rate_i,
  input  logic signed [FLOW_W-1:0]       flow_i,
  output logic signed [OUT_W-1:0]        comp_o
);

  logic signed [FILT_W-1:0]   filt_q, filt_d;
  logic signed [WIN_W-1:0]    win_q, win_d;
  logic signed [MUL_A_W-1:0]  a_q, a_d;
  logic signed [MUL_HI_W-1:0] hi_q, hi_d;
  logic [MUL_B_W-1:0]         lo_q, lo_d;
  logic signed [FLOW_W-1:0]   flow_q, flow_d;
  logic signed [SUB_W-1:0]    sub_q, sub_d;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [MUL_HI_W-1:0] addend;
  logic signed [MUL_HI_W-1:0] hi_sum;
  logic signed [MUL_P_W-1:0]  prod;
  logic signed [STEP_W-1:0]   step;
  logic signed [FSUM_W-1:0]   fsum;
  logic signed [FILT_W-1:0]   filt_new;
  logic signed [ADD_W-1:0]    wadd;
  logic signed [WSUM_W-1:0]   wsum;
  logic signed [WIN_W-1:0]    win_new;
  logic signed [WIN_W:0]      wrnd;
  logic signed [CDIFF_W-1:0]  cdiff;

  // rounding half is preloaded into the accumulator, so the product
  // comes out already rounded and only a bit slice is needed
  localparam logic [MUL_HI_W-1:0] RND_FILT =
    {{(MUL_HI_W-ALPHA_FRAC){1'b0}}, 1'b1, {(ALPHA_FRAC-1){1'b0}}};
  localparam logic [MUL_HI_W-1:0] RND_WIN =
    {{(MUL_HI_W-GAIN_K){1'b0}}, 1'b1, {(GAIN_K-1){1'b0}}};
  localparam logic [WIN_W:0] RND_OUT =
    {{(WIN_W+1-RND_SH){1'b0}}, 1'b1, {(RND_SH-1){1'b0}}};

  always_comb begin
    diff = {{(DIFF_W-RATE_SH_W){rate_i[SAMPLE_WIDTH-1]}}, rate_i, {FILTER_FRAC_BITS{1'b0}}}
         - {{(DIFF_W-FILT_W){filt_q[FILT_W-1]}}, filt_q};

    // one multiplier bit per cycle, msb of b has negative weight
    addend = lo_q[0] ? {{(MUL_HI_W-MUL_A_W){a_q[MUL_A_W-1]}}, a_q} : '0;
    hi_sum = ctrl_i.mul_last ? (hi_q - addend) : (hi_q + addend);
    prod   = {hi_q, lo_q};

    step = prod[ALPHA_FRAC +: STEP_W];
    fsum = {{(FSUM_W-FILT_W){filt_q[FILT_W-1]}}, filt_q}
         + {{(FSUM_W-STEP_W){step[STEP_W-1]}}, step};
    if ((&fsum[FSUM_W-1:FILT_W-1]) || !(|fsum[FSUM_W-1:FILT_W-1])) begin
      filt_new = fsum[FILT_W-1:0];
    end else if (fsum[FSUM_W-1]) begin
      filt_new = {1'b1, {(FILT_W-1){1'b0}}};
    end else begin
      filt_new = {1'b0, {(FILT_W-1){1'b1}}};
    end

    wadd = prod[GAIN_K +: ADD_W];
    wsum = {{(WSUM_W-WIN_W){win_q[WIN_W-1]}}, win_q}
         + {{(WSUM_W-ADD_W){wadd[ADD_W-1]}}, wadd};
    if ((&wsum[WSUM_W-1:WIN_W-1]) || !(|wsum[WSUM_W-1:WIN_W-1])) begin
      win_new = wsum[WIN_W-1:0];
    end else if (wsum[WSUM_W-1]) begin
      win_new = {1'b1, {(WIN_W-1){1'b0}}};
    end else begin
      win_new = {1'b0, {(WIN_W-1){1'b1}}};
    end

    wrnd  = {win_q[WIN_W-1], win_q} + RND_OUT;
    cdiff = {{(CDIFF_W-FSH_W){flow_q[FLOW_W-1]}}, flow_q, {OUT_FRAC{1'b0}}}
          - {{(CDIFF_W-SUB_W){sub_q[SUB_W-1]}}, sub_q};
    if ((&cdiff[CDIFF_W-1:OUT_W-1]) || !(|cdiff[CDIFF_W-1:OUT_W-1])) begin
      comp_o = cdiff[OUT_W-1:0];
    end else if (cdiff[CDIFF_W-1]) begin
      comp_o = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      comp_o = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_comb begin
    filt_d = filt_q;
    win_d  = win_q;
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    flow_d = flow_q;
    sub_d  = sub_q;
    if (ctrl_i.load_filt) begin
      a_d  = diff;
      hi_d = RND_FILT;
      lo_d = {{(MUL_B_W-ALPHA_W){1'b0}}, alpha_i};
    end else if (ctrl_i.upd_filt) begin
      // new filter value feeds the window multiply right away
      filt_d = filt_new;
      a_d    = {{(MUL_A_W-FILT_W){filt_new[FILT_W-1]}}, filt_new};
      hi_d   = RND_WIN;
      lo_d   = {{(MUL_B_W-GAIN_W){gain_i[GAIN_W-1]}}, gain_i};
    end else if (ctrl_i.mul_step) begin
      hi_d = {hi_sum[MUL_HI_W-1], hi_sum[MUL_HI_W-1:1]};
      lo_d = {hi_sum[0], lo_q[MUL_B_W-1:1]};
    end
    if (ctrl_i.upd_win) begin
      win_d = win_new;
    end else if (ctrl_i.flow_out) begin
      win_d = '0;
    end
    if (ctrl_i.load_flow) begin
      flow_d = flow_i;
      sub_d  = wrnd[WIN_W:RND_SH];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
      win_q  <= '0;
    end else begin
      filt_q <= filt_d;
      win_q  <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    flow_q <= flow_d;
    sub_q  <= sub_d;
  end

endmodule

@@ rtl/fgc_checker.sv @@
// ----------------------------------------------------------------------------
// fgc_checker
// port-level checks of the flow gyro compensator, bound to the top level
// ----------------------------------------------------------------------------
`include "flow_gyro_compensator_unit_macros.svh"

module fgc_checker import fgc_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    in_command_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [OUT_W-1:0] comp_dx_i,
  input logic signed [OUT_W-1:0] comp_dy_i
);

  // every word keeps the block busy: it is not ready in the cycle after it takes a word
  `FGC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)

  // a fresh result only ever follows an accepted flow frame, through the frame registers and the output register
  `FGC_ASSERT_NOW(a_result_from_frame, $rose(out_valid_i), $past(in_valid_i && in_ready_i && (in_command_i == CMD_FLOW), 2))

  // a stalled result holds
  `FGC_ASSERT_NEXT(a_stall_holds, out_valid_i && !out_ready_i, out_valid_i && $stable(comp_dx_i) && $stable(comp_dy_i))

endmodule

bind flow_gyro_compensator_unit fgc_checker u_fgc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .comp_dx_i    (out_o.comp_dx),
  .comp_dy_i    (out_o.comp_dy)
);

@@ verif/flow_gyro_compensator_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flow_gyro_compensator_unit_tb
// drives gyro sample and flow frame words into the compensator and checks
// every compensated delta word against a cycle-free model of the filters,
// the window sums and the output saturation, under several register
// settings and with random idling on both word channels
// ----------------------------------------------------------------------------
module flow_gyro_compensator_unit_tb import fgc_pkg::*; ();

  localparam int AXES       = 2;
  localparam int GYRO_DRAIN = 60;  // cycles a gyro word may still be in work

  typedef struct {
    logic signed [OUT_W-1:0] dx;
    logic signed [OUT_W-1:0] dy;
  } deltas_t;

  logic clk_i;
  logic rst_ni;

  fgc_in_if  in_ch ();
  fgc_out_if out_ch ();
  fgc_cfg_if cfg_ch ();

  flow_gyro_compensator_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // model state, index 0 is x and 1 is y
  longint  filt_st  [AXES];
  longint  win_st   [AXES];
  longint  alpha_st [AXES];
  longint  gain_st  [AXES];

  deltas_t pending_deltas[$];
  int      mismatches;
  int      tx_idle_pct;
  int      rx_stall_pct;
  logic    rx_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- model
  function automatic longint sat_to(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // round half up, then drop s fraction bits
  function automatic longint round_drop(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic void track_gyro_axis(int a, logic signed [SAMPLE_WIDTH-1:0] rate);
    longint diff;
    longint step;
    diff = (longint'(rate) <<< FILTER_FRAC_BITS) - filt_st[a];
    step = round_drop(alpha_st[a] * diff, ALPHA_FRAC);
    filt_st[a] = sat_to(filt_st[a] + step, FILT_W);
    win_st[a] = sat_to(win_st[a] + round_drop(gain_st[a] * filt_st[a],
                       GAIN_FRAC + FILTER_FRAC_BITS - WIN_FRAC), WIN_W);
  endfunction

  function automatic logic signed [OUT_W-1:0] compensate_axis(int a,
      logic signed [FLOW_W-1:0] flow);
    longint c;
    c = sat_to((longint'(flow) <<< OUT_FRAC) - round_drop(win_st[a], WIN_FRAC - OUT_FRAC),
               OUT_W);
    win_st[a] = 0;
    return c[OUT_W-1:0];
  endfunction

  function automatic void model_word(cmd_e cmd, logic [15:0] rx, logic [15:0] ry,
                                     logic [15:0] fx, logic [15:0] fy);
    deltas_t d;
    if (cmd == CMD_GYRO) begin
      track_gyro_axis(0, rx);
      track_gyro_axis(1, ry);
    end else begin
      d.dx = compensate_axis(0, fx);
      d.dy = compensate_axis(1, fy);
      pending_deltas.push_back(d);
    end
  endfunction

  // ---------------------------------------------------------- word drivers
  task automatic send_word(cmd_e cmd, logic [15:0] rx, logic [15:0] ry,
                           logic [15:0] fx, logic [15:0] fy);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.rate_x  <= rx;
    in_ch.rate_y  <= ry;
    in_ch.flow_dx <= fx;
    in_ch.flow_dy <= fy;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    model_word(cmd, rx, ry, fx, fy);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_deltas.size() != 0);
  endtask

  // block idle: no result owed and no gyro word left in work
  task automatic settle();
    wait_drained();
    repeat (GYRO_DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_ALPHA_X:   alpha_st[0] = longint'(val[ALPHA_W-1:0]);
      CFG_ALPHA_Y:   alpha_st[1] = longint'(val[ALPHA_W-1:0]);
      CFG_GAIN_DT_X: gain_st[0]  = longint'($signed(val[GAIN_W-1:0]));
      CFG_GAIN_DT_Y: gain_st[1]  = longint'($signed(val[GAIN_W-1:0]));
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [15:0] ax, logic [15:0] ay, logic [23:0] gx,
                           logic [23:0] gy);
    write_reg(CFG_ALPHA_X, CFG_DATA_W'(ax));
    write_reg(CFG_ALPHA_Y, CFG_DATA_W'(ay));
    write_reg(CFG_GAIN_DT_X, gx);
    write_reg(CFG_GAIN_DT_Y, gy);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------- receiver and check
  initial begin
    deltas_t d;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        if (pending_deltas.size() == 0) begin
          $display("%0t unexpected word: comp_dx %0d comp_dy %0d", $time,
                   out_ch.comp_dx, out_ch.comp_dy);
          mismatches++;
        end else begin
          d = pending_deltas.pop_front();
          if (out_ch.comp_dx !== d.dx) begin
            $display("%0t comp_dx expected %0d actual %0d", $time, d.dx, out_ch.comp_dx);
            mismatches++;
          end
          if (out_ch.comp_dy !== d.dy) begin
            $display("%0t comp_dy expected %0d actual %0d", $time, d.dy, out_ch.comp_dy);
            mismatches++;
          end
        end
      end
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ------------------------------------------------------------- stimulus
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      4:       return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(7))
      0:       return 24'h7fffff;
      1:       return 24'h800000;
      2:       return 24'h000000;
      3, 4:    return 24'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_alpha();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h0001;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic test_defaults();
    send_word(CMD_FLOW, 16'h1234, 16'hedcb, 16'h0000, 16'h0000);  // empty window
    send_word(CMD_GYRO, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_word(CMD_GYRO, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
    send_word(CMD_GYRO, 16'h8000, 16'h7fff, 16'h5555, 16'haaaa);
    send_word(CMD_GYRO, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_GYRO, 16'hffff, 16'h0001, 16'h0000, 16'h0000);
    send_word(CMD_FLOW, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_word(CMD_FLOW, 16'h0000, 16'h0000, 16'h8000, 16'h7fff);  // window just cleared
    send_word(CMD_GYRO, 16'haaaa, 16'h5555, 16'hffff, 16'hffff);
    send_word(CMD_FLOW, 16'hffff, 16'hffff, 16'hffff, 16'h0001);
    send_word(CMD_GYRO, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
    send_word(CMD_FLOW, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_reg_extremes();
    logic [15:0] ax [3] = '{16'h0000, 16'hffff, 16'h8000};
    logic [15:0] ay [3] = '{16'hffff, 16'h0000, 16'h0001};
    logic [23:0] gx [3] = '{24'h000000, 24'h7fffff, 24'h800000};
    logic [23:0] gy [3] = '{24'h800000, 24'h000000, 24'h7fffff};
    for (int s = 0; s < 3; s++) begin
      settle();
      load_regs(ax[s], ay[s], gx[s], gy[s]);
      send_word(CMD_GYRO, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
      send_word(CMD_GYRO, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
      send_word(CMD_GYRO, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
      send_word(CMD_FLOW, 16'h0000, 16'h0000, 16'h7fff, 16'h8000);
    end
  endtask

  // full gain on a settled filter drives the window sum into both rails
  task automatic test_window_rails();
    settle();
    load_regs(16'hffff, 16'hffff, 24'h7fffff, 24'h800000);
    repeat (520) send_word(CMD_GYRO, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
    send_word(CMD_FLOW, 16'h0000, 16'h0000, 16'h8000, 16'h7fff);
    settle();
    load_regs(16'hffff, 16'hffff, 24'h800000, 24'h7fffff);
    repeat (520) send_word(CMD_GYRO, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
    send_word(CMD_FLOW, 16'h0000, 16'h0000, 16'h7fff, 16'h8000);
  endtask

  task automatic test_backpressure();
    settle();
    load_regs(16'd3874, 16'd2761, 24'd134380, 24'd153015);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    send_word(CMD_GYRO, pick_sample(), pick_sample(), pick_sample(), pick_sample());
    repeat (10) send_word(CMD_FLOW, pick_sample(), pick_sample(), pick_sample(),
                          pick_sample());
    wait_drained();
    repeat (4) send_word(CMD_FLOW, pick_sample(), pick_sample(), pick_sample(),
                         pick_sample());
  endtask

  task automatic test_random();
    int idle_tx [4] = '{0, 61, 0, 12};
    int idle_rx [4] = '{0, 0, 61, 12};
    cmd_e cmd;
    for (int p = 0; p < 4; p++) begin
      settle();
      load_regs(pick_alpha(), pick_alpha(), pick_gain(), pick_gain());
      tx_idle_pct  = idle_tx[p];
      rx_stall_pct = idle_rx[p];
      repeat (80) begin
        cmd = ($urandom_range(4) == 0) ? CMD_FLOW : CMD_GYRO;
        send_word(cmd, pick_sample(), pick_sample(), pick_sample(), pick_sample());
      end
    end
  endtask

  // ------------------------------------------------------------ main flow
  initial begin
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_GYRO;
    in_ch.rate_x  <= '0;
    in_ch.rate_y  <= '0;
    in_ch.flow_dx <= '0;
    in_ch.flow_dy <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_ALPHA_X;
    cfg_ch.data   <= '0;
    rx_hold       <= 1'b0;
    mismatches   = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    alpha_st[0]  = longint'(ALPHA_X_RST);
    alpha_st[1]  = longint'(ALPHA_Y_RST);
    gain_st[0]   = longint'(GAIN_DT_X_RST);
    gain_st[1]   = longint'(GAIN_DT_Y_RST);
    for (int a = 0; a < AXES; a++) begin
      filt_st[a] = 0;
      win_st[a]  = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_reg_extremes();
    test_window_rails();
    test_backpressure();
    test_random();
    settle();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
